>>> hw/rtl/command_frame_builder_unit_assert.svh
`ifndef COMMAND_FRAME_BUILDER_UNIT_ASSERT_SVH
`define COMMAND_FRAME_BUILDER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define CFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define CFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CFB_ASSERT(lbl, prop, msg)

`define CFB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

>>> hw/rtl/cfb_pkg.sv
package cfb_pkg;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_NOFRAME = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NOFRAME = 2'd1;
  localparam logic [1:0] ERR_ABANDON = 2'd2;

  localparam logic REG_HEADER  = 1'b0;
  localparam logic REG_CONTROL = 1'b1;

  localparam logic [7:0] HEADER_RESET  = 8'h79;
  localparam logic [7:0] CONTROL_RESET = 8'h58;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_CMD        = 3'd4;
  localparam logic [STEP_W-1:0] STEP_START_LAST = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DATA_LAST  = 3'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] err;
    logic       trailer;
    logic [7:0] data;
    logic [7:0] len;
    logic [7:0] hdr;
    logic [7:0] ctrl;
    logic [7:0] sum;
    logic [7:0] xsum;
  } job_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       valid;
    logic       eof;
    logic [1:0] err;
    logic       last;
  } res_t;

endpackage

>>> hw/rtl/cfb_front.sv
module cfb_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_operation,
  input  logic [7:0]                 in_command,
  input  logic [7:0]                 in_payload_length,
  input  logic [7:0]                 in_data_byte,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfb_pkg::APB_AW-1:0] paddr,
  input  logic [cfb_pkg::APB_DW-1:0] pwdata,
  output logic [cfb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       jq_full,
  output logic                       jq_push,
  output cfb_pkg::job_t              jq_job
);

  logic [7:0] header_r, header_nxt;
  logic [7:0] control_r, control_nxt;
  logic       open_r, open_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] xsum_r, xsum_nxt;
  logic       accept;
  logic       cfg_wr;

  assign accept  = push && !jq_full;
  assign full    = jq_full;
  assign jq_push = accept;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    header_nxt  = header_r;
    control_nxt = control_r;
    if (cfg_wr) begin
      if (paddr[2] == cfb_pkg::REG_HEADER) begin
        header_nxt = pwdata[7:0];
      end else begin
        control_nxt = pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == cfb_pkg::REG_HEADER) begin
      prdata = {{(cfb_pkg::APB_DW-8){1'b0}}, header_r};
    end else begin
      prdata = {{(cfb_pkg::APB_DW-8){1'b0}}, control_r};
    end
  end

  always_comb begin
    open_nxt     = open_r;
    remain_nxt   = remain_r;
    sum_nxt      = sum_r;
    xsum_nxt     = xsum_r;
    jq_job.kind    = cfb_pkg::KIND_NOFRAME;
    jq_job.err     = cfb_pkg::ERR_NOFRAME;
    jq_job.trailer = 1'b0;
    jq_job.data    = in_data_byte;
    jq_job.len     = in_payload_length;
    jq_job.hdr     = header_r;
    jq_job.ctrl    = control_r;
    jq_job.sum     = sum_r;
    jq_job.xsum    = xsum_r;
    if (in_operation == cfb_pkg::OP_START) begin
      jq_job.kind    = cfb_pkg::KIND_START;
      jq_job.err     = open_r ? cfb_pkg::ERR_ABANDON : cfb_pkg::ERR_NONE;
      jq_job.trailer = (in_payload_length == 8'd0);
      jq_job.data    = in_command;
      jq_job.sum     = in_payload_length + control_r + in_command;
      jq_job.xsum    = in_payload_length ^ control_r ^ in_command;
    end else if (open_r) begin
      jq_job.kind    = cfb_pkg::KIND_DATA;
      jq_job.err     = cfb_pkg::ERR_NONE;
      jq_job.trailer = (remain_r == 8'd1);
      jq_job.sum     = sum_r + in_data_byte;
      jq_job.xsum    = xsum_r ^ in_data_byte;
    end
    if (accept && jq_job.kind != cfb_pkg::KIND_NOFRAME) begin
      open_nxt   = !jq_job.trailer;
      remain_nxt = (in_operation == cfb_pkg::OP_START) ? in_payload_length : remain_r - 8'd1;
      sum_nxt    = jq_job.sum;
      xsum_nxt   = jq_job.xsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= cfb_pkg::HEADER_RESET;
      control_r <= cfb_pkg::CONTROL_RESET;
      open_r    <= 1'b0;
      remain_r  <= 8'd0;
      sum_r     <= 8'd0;
      xsum_r    <= 8'd0;
    end else begin
      header_r  <= header_nxt;
      control_r <= control_nxt;
      open_r    <= open_nxt;
      remain_r  <= remain_nxt;
      sum_r     <= sum_nxt;
      xsum_r    <= xsum_nxt;
    end
  end

endmodule

>>> hw/rtl/cfb_jobq.sv
module cfb_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  cfb_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output cfb_pkg::job_t rd_job
);

  cfb_pkg::job_t                mem_r [cfb_pkg::JOBQ_DEPTH];
  logic [cfb_pkg::JOBQ_AW-1:0]  wptr_r, wptr_nxt;
  logic [cfb_pkg::JOBQ_AW-1:0]  rptr_r, rptr_nxt;
  logic [cfb_pkg::JOBQ_AW:0]    count_r, count_nxt;
  logic                         do_wr;
  logic                         do_rd;

  assign full     = (count_r == (cfb_pkg::JOBQ_AW + 1)'(cfb_pkg::JOBQ_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wptr_nxt  = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/cfb_back.sv
`include "command_frame_builder_unit_assert.svh"

module cfb_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          jq_valid,
  input  cfb_pkg::job_t jq_job,
  output logic          jq_pop,
  input  logic          pop,
  output logic          empty,
  output cfb_pkg::res_t res
);

  logic [cfb_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [cfb_pkg::STEP_W-1:0] last_step;
  logic                       out_valid_r, out_valid_nxt;
  cfb_pkg::res_t              out_r;
  cfb_pkg::res_t              cur;
  logic                       advance;
  logic                       emit;
  logic                       is_last;
  logic                       in_trailer;

  assign advance = !out_valid_r || pop;
  assign emit    = jq_valid && advance;
  assign is_last = (step_r == last_step);
  assign jq_pop  = emit && is_last;
  assign empty   = !out_valid_r;
  assign res     = out_r;

  always_comb begin
    if (jq_job.kind == cfb_pkg::KIND_START) begin
      last_step = jq_job.trailer ? cfb_pkg::STEP_START_LAST : cfb_pkg::STEP_CMD;
    end else if (jq_job.kind == cfb_pkg::KIND_DATA) begin
      last_step = jq_job.trailer ? cfb_pkg::STEP_DATA_LAST : '0;
    end else begin
      last_step = '0;
    end
  end

  always_comb begin
    in_trailer = ((jq_job.kind == cfb_pkg::KIND_START) && (step_r > cfb_pkg::STEP_CMD)) ||
                 ((jq_job.kind == cfb_pkg::KIND_DATA) && (step_r != '0));
    cur.valid = (jq_job.kind != cfb_pkg::KIND_NOFRAME);
    cur.eof   = in_trailer && is_last;
    cur.err   = jq_job.err;
    cur.last  = is_last;
    if (in_trailer) begin
      cur.line_byte = is_last ? jq_job.xsum : jq_job.sum;
    end else if (jq_job.kind == cfb_pkg::KIND_START) begin
      case (step_r)
        3'd0:    cur.line_byte = jq_job.hdr;
        3'd1:    cur.line_byte = jq_job.len;
        3'd2:    cur.line_byte = 8'd0;
        3'd3:    cur.line_byte = jq_job.ctrl;
        default: cur.line_byte = jq_job.data;
      endcase
    end else if (jq_job.kind == cfb_pkg::KIND_DATA) begin
      cur.line_byte = jq_job.data;
    end else begin
      cur.line_byte = 8'd0;
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (emit) begin
      step_nxt = is_last ? '0 : step_r + 1'b1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CFB_ASSERT(a_eof_is_last, (out_valid_r && out_r.eof) |-> out_r.last, "end of frame on a result that is not the last of its item")
  `CFB_ASSERT(a_step_bound, jq_valid |-> (step_r <= last_step), "result step ran past the end of its item")
  `CFB_ASSERT(a_pop_only_last, jq_pop |=> (step_r == '0), "step counter not rewound after an item completed")
  `CFB_ASSERT(a_hold_when_stalled, (out_valid_r && !pop) |=> ($stable(out_r) && out_valid_r), "waiting result changed while stalled")

endmodule

>>> hw/rtl/command_frame_builder_unit.sv
// Command frame builder. A start item (in_operation 0) yields the header byte, the length low
// and high bytes, the control byte and the command, plus the sum and XOR trailer when the length
// is zero; each payload item yields its byte, plus the trailer after the last one. The input side
// takes one item per cycle while its four-entry job queue has room; the result side gives one
// byte per cycle while results are popped, so a start item yields five or seven bytes, a
// payload item one, or three when it closes the frame. The result sequencer's single byte
// per cycle sets the sustained rate. Header and control bytes sit at APB byte addresses 0 and 4.
module command_frame_builder_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic                       in_operation,
  input  logic [7:0]                 in_command,
  input  logic [7:0]                 in_payload_length,
  input  logic [7:0]                 in_data_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic                       out_byte_valid,
  output logic                       out_end_of_frame,
  output logic [1:0]                 out_error,
  output logic                       out_last_of_run,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cfb_pkg::APB_AW-1:0] paddr,
  input  logic [cfb_pkg::APB_DW-1:0] pwdata,
  output logic [cfb_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic          jq_full;
  logic          jq_push;
  cfb_pkg::job_t jq_wr_job;
  logic          jq_valid;
  logic          jq_pop;
  cfb_pkg::job_t jq_rd_job;
  cfb_pkg::res_t res;

  cfb_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_operation      (in_operation),
    .in_command        (in_command),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .jq_full           (jq_full),
    .jq_push           (jq_push),
    .jq_job            (jq_wr_job)
  );

  cfb_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (jq_push),
    .wr_job   (jq_wr_job),
    .full     (jq_full),
    .rd_en    (jq_pop),
    .rd_valid (jq_valid),
    .rd_job   (jq_rd_job)
  );

  cfb_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .jq_valid (jq_valid),
    .jq_job   (jq_rd_job),
    .jq_pop   (jq_pop),
    .pop      (pop),
    .empty    (empty),
    .res      (res)
  );

  assign out_byte         = res.line_byte;
  assign out_byte_valid   = res.valid;
  assign out_end_of_frame = res.eof;
  assign out_error        = res.err;
  assign out_last_of_run  = res.last;

endmodule
